>>> hdl/ffdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffdm_pkg
// Types and constants shared by the divergence monitor modules.
// ----------------------------------------------------------------------------
package ffdm_pkg;

    localparam int FIELD_W   = 32;
    localparam int COORD_W   = 10;
    localparam int DIV_W     = 48;
    localparam int L1_W      = 63;
    localparam int SSUM_W    = 64;
    localparam int BOX_W     = 12;
    localparam int TOL_W     = 47;
    localparam int RANK_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 47;
    localparam int DIFF_W    = FIELD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int FRAC_W    = 16;
    localparam int TERM_W    = PROD_W - FRAC_W;
    localparam int SUM_W     = TERM_W + 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_RANK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd4;

    localparam logic [FIELD_W-1:0] INV_WIDTH_RESET = 32'h0001_0000;
    localparam logic [RANK_W-1:0]  RANK_RESET      = 2'd3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] bx_low;
        logic signed [FIELD_W-1:0] bx_high;
        logic signed [FIELD_W-1:0] by_low;
        logic signed [FIELD_W-1:0] by_high;
        logic signed [FIELD_W-1:0] bz_low;
        logic signed [FIELD_W-1:0] bz_high;
        logic [COORD_W-1:0]        cell_x;
        logic [COORD_W-1:0]        cell_y;
        logic [COORD_W-1:0]        cell_z;
        logic                      last_cell;
    } in_item_t;

    typedef struct packed {
        logic signed [DIV_W-1:0]  divergence;
        logic [L1_W-1:0]          l1_sum;
        logic signed [SSUM_W-1:0] signed_sum;
        logic [DIV_W-1:0]         max_abs;
        logic signed [BOX_W-1:0]  box_min_x;
        logic signed [BOX_W-1:0]  box_max_x;
        logic signed [BOX_W-1:0]  box_min_y;
        logic signed [BOX_W-1:0]  box_max_y;
        logic signed [BOX_W-1:0]  box_min_z;
        logic signed [BOX_W-1:0]  box_max_z;
        logic                     convex;
        logic                     sweep_done;
    } out_item_t;

    // Register set seen by the front end
    typedef struct packed {
        logic [FIELD_W-1:0] inv_width_x;
        logic [FIELD_W-1:0] inv_width_y;
        logic [FIELD_W-1:0] inv_width_z;
        logic [RANK_W-1:0]  grid_rank;
        logic [TOL_W-1:0]   tolerance;
    } cfg_t;

    // Classified cell passed from front end to back end
    typedef struct packed {
        logic signed [DIV_W-1:0] div;
        logic [DIV_W-1:0]        mag;
        logic                    above;
        logic [COORD_W-1:0]      cx;
        logic [COORD_W-1:0]      cy;
        logic [COORD_W-1:0]      cz;
        logic                    last;
    } work_t;

endpackage
`default_nettype wire

>>> hdl/ffdm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffdm_front
// Four-stage front end: face differences, scaled terms, saturated sum,
// magnitude and tolerance test.
// ----------------------------------------------------------------------------
module ffdm_front
    import ffdm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    output logic          push,
    output work_t         push_item,
    input  wire logic     queue_full
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic free1, free2, free3, free4;

    // stage 1
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [COORD_W-1:0] cx1_reg, cy1_reg, cz1_reg;
    logic last1_reg;
    // stage 2
    logic signed [TERM_W-1:0] tx_reg, ty_reg, tz_reg;
    logic [COORD_W-1:0] cx2_reg, cy2_reg, cz2_reg;
    logic last2_reg;
    // stage 3
    logic signed [DIV_W-1:0] div3_reg;
    logic [COORD_W-1:0] cx3_reg, cy3_reg, cz3_reg;
    logic last3_reg;
    // stage 4
    work_t w4_reg;

    logic signed [PROD_W-1:0] px, py, pz;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIV_W-1:0]  div_sat;
    logic [DIV_W:0]           mag_wide;
    logic [DIV_W-1:0]         mag;

    assign free4 = !v4_reg || !queue_full;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;

    assign in_stall  = !free1;
    assign push      = v4_reg && !queue_full;
    assign push_item = w4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (free1) v1_reg <= in_valid;
            if (free2) v2_reg <= v1_reg;
            if (free3) v3_reg <= v2_reg;
            if (free4) v4_reg <= v3_reg;
        end
    end

    // Product of signed difference and unsigned reciprocal; the arithmetic
    // shift floors toward minus infinity.
    assign px = dx_reg * $signed({1'b0, cfg.inv_width_x});
    assign py = dy_reg * $signed({1'b0, cfg.inv_width_y});
    assign pz = dz_reg * $signed({1'b0, cfg.inv_width_z});

    assign sum = {{2{tx_reg[TERM_W-1]}}, tx_reg} + {{2{ty_reg[TERM_W-1]}}, ty_reg}
               + {{2{tz_reg[TERM_W-1]}}, tz_reg};

    always_comb
    begin
        if (sum[SUM_W-1:DIV_W-1] == '0 || sum[SUM_W-1:DIV_W-1] == '1)
            div_sat = sum[DIV_W-1:0];
        else if (sum[SUM_W-1])
            div_sat = {1'b1, {(DIV_W-1){1'b0}}};
        else
            div_sat = {1'b0, {(DIV_W-1){1'b1}}};
    end

    assign mag_wide = div3_reg[DIV_W-1] ? (DIV_W+1)'(0) - {div3_reg[DIV_W-1], div3_reg}
                                        : {1'b0, div3_reg};
    assign mag = mag_wide[DIV_W-1:0];

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            dx_reg    <= {in_item.bx_high[FIELD_W-1], in_item.bx_high}
                       - {in_item.bx_low[FIELD_W-1], in_item.bx_low};
            dy_reg    <= {in_item.by_high[FIELD_W-1], in_item.by_high}
                       - {in_item.by_low[FIELD_W-1], in_item.by_low};
            dz_reg    <= {in_item.bz_high[FIELD_W-1], in_item.bz_high}
                       - {in_item.bz_low[FIELD_W-1], in_item.bz_low};
            cx1_reg   <= in_item.cell_x;
            cy1_reg   <= in_item.cell_y;
            cz1_reg   <= in_item.cell_z;
            last1_reg <= in_item.last_cell;
        end
        if (free2)
        begin
            tx_reg    <= px[PROD_W-1:FRAC_W];
            // drop y below rank two and z below rank three
            ty_reg    <= cfg.grid_rank[1] ? py[PROD_W-1:FRAC_W] : '0;
            tz_reg    <= (cfg.grid_rank == 2'd3) ? pz[PROD_W-1:FRAC_W] : '0;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            cz2_reg   <= cz1_reg;
            last2_reg <= last1_reg;
        end
        if (free3)
        begin
            div3_reg  <= div_sat;
            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;
            cz3_reg   <= cz2_reg;
            last3_reg <= last2_reg;
        end
        if (free4)
        begin
            w4_reg.div   <= div3_reg;
            w4_reg.mag   <= mag;
            w4_reg.above <= mag > {1'b0, cfg.tolerance};
            w4_reg.cx    <= cx3_reg;
            w4_reg.cy    <= cy3_reg;
            w4_reg.cz    <= cz3_reg;
            w4_reg.last  <= last3_reg;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ffdm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffdm_queue
// Short first-in first-out queue of classified cells between front and back.
// ----------------------------------------------------------------------------
module ffdm_queue
    import ffdm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire work_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output work_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    work_t entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

>>> hdl/ffdm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffdm_back
// Back end: sweep accumulators, bounding box, convexity and output register.
// ----------------------------------------------------------------------------
module ffdm_back
    import ffdm_pkg::*;
#(
    parameter int GRID_DIM = 1024
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  empty,
    input  wire work_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output out_item_t  out_item
);

    localparam logic signed [BOX_W-1:0] BOX_LO_RESET = BOX_W'(GRID_DIM);
    localparam logic signed [BOX_W-1:0] BOX_HI_RESET = '1;

    logic [L1_W-1:0]          l1_reg, l1_next;
    logic signed [SSUM_W-1:0] ssum_reg, ssum_next;
    logic [DIV_W-1:0]         peak_reg, peak_next;
    logic signed [BOX_W-1:0]  box_lo_reg [3];
    logic signed [BOX_W-1:0]  box_hi_reg [3];
    logic signed [BOX_W-1:0]  box_lo_next [3];
    logic signed [BOX_W-1:0]  box_hi_next [3];
    logic                     convex_reg, convex_next;
    logic                     out_valid_reg;
    out_item_t                out_item_reg;

    logic [L1_W:0]            l1_wide;
    logic signed [SSUM_W:0]   ssum_wide;
    logic signed [BOX_W-1:0]  coord [3];
    logic                     in_box;

    assign pop       = !empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign coord[0] = {{(BOX_W-COORD_W){1'b0}}, head.cx};
    assign coord[1] = {{(BOX_W-COORD_W){1'b0}}, head.cy};
    assign coord[2] = {{(BOX_W-COORD_W){1'b0}}, head.cz};

    assign l1_wide   = {1'b0, l1_reg} + (L1_W+1)'(head.mag);
    assign ssum_wide = {ssum_reg[SSUM_W-1], ssum_reg}
                     + {{(SSUM_W+1-DIV_W){head.div[DIV_W-1]}}, head.div};

    always_comb
    begin
        l1_next   = l1_wide[L1_W] ? '1 : l1_wide[L1_W-1:0];
        if (ssum_wide[SSUM_W] != ssum_wide[SSUM_W-1])
            ssum_next = ssum_wide[SSUM_W] ? {1'b1, {(SSUM_W-1){1'b0}}}
                                          : {1'b0, {(SSUM_W-1){1'b1}}};
        else
            ssum_next = ssum_wide[SSUM_W-1:0];
        peak_next = (head.mag > peak_reg) ? head.mag : peak_reg;

        in_box = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            box_lo_next[a] = box_lo_reg[a];
            box_hi_next[a] = box_hi_reg[a];
            if (head.above)
            begin
                if (coord[a] > box_hi_reg[a]) box_hi_next[a] = coord[a];
                if (coord[a] < box_lo_reg[a]) box_lo_next[a] = coord[a];
            end
            if (coord[a] > box_hi_reg[a] || coord[a] < box_lo_reg[a])
                in_box = 1'b0;
        end
        // a quiet cell inside the box breaks convexity
        convex_next = (!head.above && in_box) ? 1'b0 : convex_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            l1_reg        <= '0;
            ssum_reg      <= '0;
            peak_reg      <= '0;
            convex_reg    <= 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                box_lo_reg[a] <= BOX_LO_RESET;
                box_hi_reg[a] <= BOX_HI_RESET;
            end
        end
        else
        begin
            if (pop)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (pop)
            begin
                // clear the sweep state after the final cell
                if (head.last)
                begin
                    l1_reg     <= '0;
                    ssum_reg   <= '0;
                    peak_reg   <= '0;
                    convex_reg <= 1'b1;
                    for (int a = 0; a < 3; a++)
                    begin
                        box_lo_reg[a] <= BOX_LO_RESET;
                        box_hi_reg[a] <= BOX_HI_RESET;
                    end
                end
                else
                begin
                    l1_reg     <= l1_next;
                    ssum_reg   <= ssum_next;
                    peak_reg   <= peak_next;
                    convex_reg <= convex_next;
                    for (int a = 0; a < 3; a++)
                    begin
                        box_lo_reg[a] <= box_lo_next[a];
                        box_hi_reg[a] <= box_hi_next[a];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg.divergence <= head.div;
            out_item_reg.l1_sum     <= l1_next;
            out_item_reg.signed_sum <= ssum_next;
            out_item_reg.max_abs    <= peak_next;
            out_item_reg.box_min_x  <= box_lo_next[0];
            out_item_reg.box_max_x  <= box_hi_next[0];
            out_item_reg.box_min_y  <= box_lo_next[1];
            out_item_reg.box_max_y  <= box_hi_next[1];
            out_item_reg.box_min_z  <= box_lo_next[2];
            out_item_reg.box_max_z  <= box_hi_next[2];
            out_item_reg.convex     <= convex_next;
            out_item_reg.sweep_done <= head.last;
        end
    end

endmodule
`default_nettype wire

>>> hdl/face_field_divergence_monitor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// face_field_divergence_monitor_unit
// Per-cell discrete divergence with running sweep totals.
//
// Input channel in_valid/in_stall/in_item carries one grid cell per item;
// output channel out_valid/out_stall/out_item returns one result per cell,
// in order. A result carries the totals including its own cell; the one with
// sweep_done set holds the final totals, after which the totals clear.
// Throughput is one item per cycle while the receiver does not stall. From
// acceptance to out_valid an item passes four front-end stages (difference,
// 33x32 multiply per axis, saturated sum, magnitude and tolerance test), the
// queue and the back-end output register.
// The user must write registers via cfg_wr_en/cfg_index/cfg_data while idle;
// the block does not enforce it. An index past the last register is ignored.
// Reset clears the totals, empties the pipeline and queue, and loads the
// register reset values. When the receiver stalls, the output holds, the
// four-entry queue fills, then the front end halts and in_stall rises.
// ----------------------------------------------------------------------------
module face_field_divergence_monitor_unit
    import ffdm_pkg::*;
#(
    parameter int GRID_DIM = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item
);

    cfg_t  cfg_reg;
    logic  push, pop, queue_full, queue_empty;
    work_t push_item, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_width_x <= INV_WIDTH_RESET;
            cfg_reg.inv_width_y <= INV_WIDTH_RESET;
            cfg_reg.inv_width_z <= INV_WIDTH_RESET;
            cfg_reg.grid_rank   <= RANK_RESET;
            cfg_reg.tolerance   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INV_WIDTH_X: cfg_reg.inv_width_x <= cfg_data[FIELD_W-1:0];
                CFG_INV_WIDTH_Y: cfg_reg.inv_width_y <= cfg_data[FIELD_W-1:0];
                CFG_INV_WIDTH_Z: cfg_reg.inv_width_z <= cfg_data[FIELD_W-1:0];
                CFG_GRID_RANK:   cfg_reg.grid_rank   <= cfg_data[RANK_W-1:0];
                CFG_TOLERANCE:   cfg_reg.tolerance   <= cfg_data[TOL_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    ffdm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    ffdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .head      (head)
    );

    ffdm_back #(
        .GRID_DIM (GRID_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

>>> dv/ffdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffdm_checker
// Watches the register port and both item channels of the divergence monitor,
// works out each cell's divergence and sweep totals on its own and compares
// every returned item with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ffdm_checker
    import ffdm_pkg::*;
#(
    parameter int GRID_DIM = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire in_item_t              in_item,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire out_item_t             out_item,
    output int                         mismatches,
    output int                         outstanding,
    output int                         cells_checked,
    output int                         sweeps_checked
);

    localparam logic signed [SUM_W-1:0] DIV_HI = (SUM_W'(1) <<< (DIV_W - 1)) - 1;
    localparam logic signed [SUM_W-1:0] DIV_LO = -(SUM_W'(1) <<< (DIV_W - 1));

    // Register copy
    logic [FIELD_W-1:0] inv_x;
    logic [FIELD_W-1:0] inv_y;
    logic [FIELD_W-1:0] inv_z;
    logic [RANK_W-1:0]  rank;
    logic [TOL_W-1:0]   tol;

    // Sweep totals
    logic [L1_W-1:0]          l1_total;
    logic signed [SSUM_W-1:0] net_total;
    logic [DIV_W-1:0]         peak_mag;
    int                       box_lo [3];
    int                       box_hi [3];
    logic                     convex_now;

    out_item_t cell_results_q [$];

    function automatic logic signed [SUM_W-1:0] face_term(
        input logic [FIELD_W-1:0] lo,
        input logic [FIELD_W-1:0] hi,
        input logic [FIELD_W-1:0] inv
    );
        logic signed [DIFF_W-1:0] diff;
        logic signed [PROD_W-1:0] prod;
        diff = {hi[FIELD_W-1], hi} - {lo[FIELD_W-1], lo};
        prod = diff * $signed({1'b0, inv});
        // arithmetic shift gives the floor
        return SUM_W'(prod >>> FRAC_W);
    endfunction

    task automatic clear_totals();
        l1_total   = '0;
        net_total  = '0;
        peak_mag   = '0;
        convex_now = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = GRID_DIM;
            box_hi[a] = -1;
        end
    endtask

    task automatic predict_cell(input in_item_t c);
        logic signed [SUM_W-1:0]  total;
        logic signed [DIV_W-1:0]  div;
        logic [DIV_W-1:0]         mag;
        logic [L1_W:0]            l1_next;
        logic signed [SSUM_W:0]   net_next;
        logic                     above;
        logic                     enclosed;
        int                       pos [3];
        out_item_t                r;
        total = face_term(c.bx_low, c.bx_high, inv_x);
        if (rank >= 2)
            total += face_term(c.by_low, c.by_high, inv_y);
        if (rank == 3)
            total += face_term(c.bz_low, c.bz_high, inv_z);
        if (total > DIV_HI)
            div = DIV_HI[DIV_W-1:0];
        else if (total < DIV_LO)
            div = DIV_LO[DIV_W-1:0];
        else
            div = total[DIV_W-1:0];
        mag = div[DIV_W-1] ? -div : div;

        if (mag > peak_mag)
            peak_mag = mag;

        l1_next = {1'b0, l1_total} + (L1_W + 1)'(mag);
        l1_total = l1_next[L1_W] ? '1 : l1_next[L1_W-1:0];

        net_next = {net_total[SSUM_W-1], net_total} + (SSUM_W + 1)'(div);
        if (net_next[SSUM_W] != net_next[SSUM_W-1])
            net_total = net_next[SSUM_W] ? {1'b1, {(SSUM_W-1){1'b0}}}
                                         : {1'b0, {(SSUM_W-1){1'b1}}};
        else
            net_total = net_next[SSUM_W-1:0];

        pos[0] = c.cell_x;
        pos[1] = c.cell_y;
        pos[2] = c.cell_z;
        above = mag > {1'b0, tol};
        if (above)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (pos[a] > box_hi[a])
                    box_hi[a] = pos[a];
                if (pos[a] < box_lo[a])
                    box_lo[a] = pos[a];
            end
        end
        else
        begin
            // an empty box encloses nothing
            enclosed = 1'b1;
            for (int a = 0; a < 3; a++)
                if (pos[a] > box_hi[a] || pos[a] < box_lo[a])
                    enclosed = 1'b0;
            if (enclosed)
                convex_now = 1'b0;
        end

        r.divergence = div;
        r.l1_sum     = l1_total;
        r.signed_sum = net_total;
        r.max_abs    = peak_mag;
        r.box_min_x  = box_lo[0][BOX_W-1:0];
        r.box_max_x  = box_hi[0][BOX_W-1:0];
        r.box_min_y  = box_lo[1][BOX_W-1:0];
        r.box_max_y  = box_hi[1][BOX_W-1:0];
        r.box_min_z  = box_lo[2][BOX_W-1:0];
        r.box_max_z  = box_hi[2][BOX_W-1:0];
        r.convex     = convex_now;
        r.sweep_done = c.last_cell;
        cell_results_q.push_back(r);

        if (c.last_cell)
            clear_totals();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (cell_results_q.size() == 0)
        begin
            mismatches++;
            $display("%0t ns: result item with none outstanding: %h", $time, got);
            return;
        end
        want = cell_results_q.pop_front();
        check_field("divergence", 64'(want.divergence), 64'(got.divergence));
        check_field("l1_sum",     64'(want.l1_sum),     64'(got.l1_sum));
        check_field("signed_sum", 64'(want.signed_sum), 64'(got.signed_sum));
        check_field("max_abs",    64'(want.max_abs),    64'(got.max_abs));
        check_field("box_min_x",  64'(want.box_min_x),  64'(got.box_min_x));
        check_field("box_max_x",  64'(want.box_max_x),  64'(got.box_max_x));
        check_field("box_min_y",  64'(want.box_min_y),  64'(got.box_min_y));
        check_field("box_max_y",  64'(want.box_max_y),  64'(got.box_max_y));
        check_field("box_min_z",  64'(want.box_min_z),  64'(got.box_min_z));
        check_field("box_max_z",  64'(want.box_max_z),  64'(got.box_max_z));
        check_field("convex",     64'(want.convex),     64'(got.convex));
        check_field("sweep_done", 64'(want.sweep_done), 64'(got.sweep_done));
        cells_checked++;
        if (got.sweep_done)
            sweeps_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x = INV_WIDTH_RESET;
            inv_y = INV_WIDTH_RESET;
            inv_z = INV_WIDTH_RESET;
            rank  = RANK_RESET;
            tol   = '0;
            clear_totals();
            cell_results_q.delete();
            mismatches     = 0;
            outstanding    = 0;
            cells_checked  = 0;
            sweeps_checked = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INV_WIDTH_X: inv_x = cfg_data[FIELD_W-1:0];
                    CFG_INV_WIDTH_Y: inv_y = cfg_data[FIELD_W-1:0];
                    CFG_INV_WIDTH_Z: inv_z = cfg_data[FIELD_W-1:0];
                    CFG_GRID_RANK:   rank  = cfg_data[RANK_W-1:0];
                    CFG_TOLERANCE:   tol   = cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_cell(in_item);
            if (out_valid && !out_stall)
                compare_result(out_item);
            outstanding = cell_results_q.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the face-field divergence monitor.
// Runs directed cells at the register and field extremes, then random sweeps
// under a series of register settings, with bursty input traffic and a
// changing output stall pattern. Checking is done by ffdm_checker.
// ----------------------------------------------------------------------------
module tb;
    import ffdm_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   RANDOM_PHASES  = 10;
    localparam int                   PHASE_CELLS    = 42;
    localparam int                   DRAIN_CYCLES   = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = 3'd7;
    localparam logic [FIELD_W-1:0]   INV_ONE        = 32'h0001_0000;
    localparam logic [FIELD_W-1:0]   INV_HALF       = 32'h0000_8000;
    localparam logic [FIELD_W-1:0]   INV_MAX        = 32'hFFFF_FFFF;
    localparam logic [FIELD_W-1:0]   F_MAX          = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0]   F_MIN          = 32'h8000_0000;
    localparam logic [TOL_W-1:0]     TOL_MAX        = '1;
    localparam logic [TOL_W-1:0]     TOL_FIVE       = 47'h5_0000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;

    int mismatches;
    int outstanding;
    int cells_checked;
    int sweeps_checked;

    int          burst_left;
    int          settings_used;
    int          idle_cycles;
    stall_mode_t stall_mode;
    int          mode_left = 0;
    int          run_left  = 0;
    logic        run_stall = 1'b0;

    face_field_divergence_monitor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    ffdm_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .cells_checked  (cells_checked),
        .sweeps_checked (sweeps_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: switch between randomly chosen stall patterns
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  out_stall = 1'b0;
            STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
            default:
            begin
                if (run_left == 0)
                begin
                    run_left  = $urandom_range(1, 12);
                    run_stall = ~run_stall;
                end
                run_left--;
                out_stall = run_stall;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic in_item_t mk_cell(
        input logic [FIELD_W-1:0] bxl, input logic [FIELD_W-1:0] bxh,
        input logic [FIELD_W-1:0] byl, input logic [FIELD_W-1:0] byh,
        input logic [FIELD_W-1:0] bzl, input logic [FIELD_W-1:0] bzh,
        input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z, input logic final_cell
    );
        in_item_t c;
        c.bx_low    = bxl;
        c.bx_high   = bxh;
        c.by_low    = byl;
        c.by_high   = byh;
        c.bz_low    = bzl;
        c.bz_high   = bzh;
        c.cell_x    = x;
        c.cell_y    = y;
        c.cell_z    = z;
        c.last_cell = final_cell;
        return c;
    endfunction

    // Upper half holds the upper face, lower half the lower face
    function automatic logic [2*FIELD_W-1:0] rand_face();
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic [FIELD_W-1:0] delta;
        lo = $urandom;
        case ($urandom_range(0, 7))
            0: hi = $urandom;
            1:
            begin
                lo = $urandom_range(0, 1) ? F_MAX : F_MIN;
                hi = $urandom_range(0, 1) ? F_MAX : F_MIN;
            end
            2: hi = lo;
            default:
            begin
                delta = $urandom_range(0, 1 << 17);
                if ($urandom_range(0, 1))
                    delta = -delta;
                hi = lo + delta;
            end
        endcase
        return {hi, lo};
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(input int base, input int span);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return COORD_W'($urandom);
            default: return COORD_W'(base + $urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] rand_inv_extreme();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return INV_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until accepted; returns at a falling edge
    task automatic send_cell(input in_item_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid = 1'b1;
        in_item  = c;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Junk above the register width checks that it is dropped
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        keep      = (CFG_DATA_W'(1) << width) - 1;
        if (width >= CFG_DATA_W)
            keep = '1;
        junk      = CFG_DATA_W'({$urandom, $urandom});
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = (value & keep) | (junk & ~keep);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input logic [FIELD_W-1:0] ix, input logic [FIELD_W-1:0] iy,
                              input logic [FIELD_W-1:0] iz, input logic [RANK_W-1:0] rk,
                              input logic [TOL_W-1:0] tl);
        wait_idle();
        write_reg(CFG_INV_WIDTH_X, CFG_DATA_W'(ix), FIELD_W);
        write_reg(CFG_INV_WIDTH_Y, CFG_DATA_W'(iy), FIELD_W);
        write_reg(CFG_INV_WIDTH_Z, CFG_DATA_W'(iz), FIELD_W);
        write_reg(CFG_GRID_RANK, CFG_DATA_W'(rk), RANK_W);
        write_reg(CFG_TOLERANCE, CFG_DATA_W'(tl), TOL_W);
        // writes past the last register must have no effect
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), '1, CFG_DATA_W);
        settings_used++;
    endtask

    task automatic random_phase(input int n_cells);
        int         sent;
        int         len;
        int         span;
        int         bx;
        int         by;
        int         bz;
        logic [63:0] fx;
        logic [63:0] fy;
        logic [63:0] fz;
        case ($urandom_range(0, 3))
            0: set_config(INV_ONE, INV_ONE, INV_ONE, RANK_RESET,
                          TOL_W'($urandom_range(0, 1 << 18)));
            1: set_config(rand_inv_extreme(), rand_inv_extreme(), rand_inv_extreme(),
                          RANK_W'($urandom_range(0, 3)), $urandom_range(0, 1) ? '0 : TOL_MAX);
            default: set_config(FIELD_W'($urandom_range(0, 1 << 18)),
                                FIELD_W'($urandom_range(0, 1 << 18)),
                                FIELD_W'($urandom_range(0, 1 << 18)),
                                RANK_W'($urandom_range(0, 3)),
                                TOL_W'($urandom_range(0, 1 << 18)));
        endcase
        sent = 0;
        while (sent < n_cells)
        begin
            len  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
            span = $urandom_range(1, 8);
            bx   = $urandom_range(0, 1023);
            by   = $urandom_range(0, 1023);
            bz   = $urandom_range(0, 1023);
            for (int i = 0; i < len; i++)
            begin
                fx = rand_face();
                fy = rand_face();
                fz = rand_face();
                send_cell(mk_cell(fx[31:0], fx[63:32], fy[31:0], fy[63:32],
                                  fz[31:0], fz[63:32], rand_coord(bx, span),
                                  rand_coord(by, span), rand_coord(bz, span),
                                  i == len - 1));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_item       = '0;
        burst_left    = 0;
        settings_used = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Register reset values: box fill, convexity, extreme sums
        send_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_cell(mk_cell(0, 1, 0, 0, 0, 0, 5, 5, 5, 1'b0));
        send_cell(mk_cell(0, 0, 0, 0, 0, 0, 5, 5, 5, 1'b0));
        send_cell(mk_cell(0, 0, 0, 0, 0, 0, 6, 5, 5, 1'b0));
        send_cell(mk_cell(F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, 1023, 1023, 1023, 1'b1));
        send_cell(mk_cell(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, 0, 0, 0, 1'b1));

        // Saturation both ways, magnitude equal to tolerance is not above
        set_config(INV_MAX, INV_MAX, INV_MAX, RANK_RESET, TOL_MAX);
        send_cell(mk_cell(F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, 9, 9, 9, 1'b0));
        send_cell(mk_cell(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, 3, 4, 5, 1'b0));
        send_cell(mk_cell(F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, 3, 4, 5, 1'b1));

        // Half-width scale: floor of negative fractions, rank one
        set_config(INV_HALF, INV_HALF, INV_HALF, 2'd1, '0);
        send_cell(mk_cell(0, 32'hFFFF_FFFF, 0, F_MAX, 0, F_MIN, 2, 2, 2, 1'b0));
        send_cell(mk_cell(0, 1, F_MIN, F_MAX, 0, 7, 2, 3, 2, 1'b0));
        send_cell(mk_cell(0, 3, 0, 0, F_MAX, 0, 2, 2, 2, 1'b1));

        // Rank two, x scale zero, threshold at exactly five
        set_config('0, INV_ONE, INV_ONE, 2'd2, TOL_FIVE);
        send_cell(mk_cell(F_MIN, F_MAX, 0, 32'h5_0000, 0, 32'h100, 10, 10, 10, 1'b0));
        send_cell(mk_cell(0, 0, 0, 32'h5_0001, F_MAX, 0, 1023, 0, 1023, 1'b0));
        send_cell(mk_cell(F_MAX, F_MIN, 1, 1, 0, 0, 500, 0, 600, 1'b1));

        // Rank zero acts as rank one
        set_config(INV_ONE, INV_ONE, INV_ONE, 2'd0, '0);
        send_cell(mk_cell(0, 2, 0, 32'h9, 0, 32'h11, 1, 1, 1, 1'b1));

        // Box at the top corner, then cells inside and outside it
        set_config(INV_ONE, INV_ONE, INV_ONE, RANK_RESET, '0);
        send_cell(mk_cell(0, 0, 0, 0, 0, 32'h1_0000, 1023, 1023, 1023, 1'b0));
        send_cell(mk_cell(0, 0, 0, 0, 0, 0, 1023, 1023, 1023, 1'b0));
        send_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_CELLS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d cells in %0d sweeps across %0d register settings,",
                 cells_checked, sweeps_checked, settings_used);
        $display("with bursty input traffic and varied output stall patterns.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
